// File: rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

    // sync pair that opens every frame
    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'hFE;

    // idle timeout after reset, in ticks
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // input item kinds
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // result item kinds
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // parser phase
    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } phase_t;

    // one input item
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       frame_ok;
        logic [7:0] frame_length;
        logic [7:0] error_count;
    } out_item_t;

endpackage

// File: rtl/slcd_parser.sv
// ----------------------------------------------------------------------------
// slcd_parser
// Frame parser state and its update for one item.
// ----------------------------------------------------------------------------
module slcd_parser
    import slcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  in_item_t    item,
    input  logic [15:0] timeout_ticks,
    output logic        has_result,
    output out_item_t   result
);

    phase_t      phase_reg,      phase_next;
    logic [7:0]  length_reg,     length_next;
    logic [7:0]  count_reg,      count_next;
    logic [7:0]  sum_reg,        sum_next;
    logic [7:0]  errors_reg,     errors_next;
    logic [15:0] idle_reg,       idle_next;
    logic        running_reg,    running_next;

    logic [15:0] idle_inc;
    logic [7:0]  count_inc;
    logic        sum_match;

    assign idle_inc  = idle_reg + 16'd1;
    assign count_inc = count_reg + 8'd1;
    assign sum_match = (sum_reg == item.rx_byte);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT1;
            length_reg  <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            errors_reg  <= '0;
            idle_reg    <= '0;
            running_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            errors_reg  <= errors_next;
            idle_reg    <= idle_next;
            running_reg <= running_next;
        end
    end

    // next state and result for the item at hand
    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        errors_next  = errors_reg;
        idle_next    = idle_reg;
        running_next = running_reg;
        has_result   = 1'b0;

        result.result_kind  = KIND_PAYLOAD;
        result.data_byte    = item.rx_byte;
        result.byte_index   = count_reg;
        result.frame_ok     = 1'b0;
        result.frame_length = length_reg;
        result.error_count  = errors_reg;

        if (item.mode == MODE_TICK)
        begin
            // idle timer, only while armed
            if (running_reg)
            begin
                if (idle_inc >= timeout_ticks)
                begin
                    running_next = 1'b0;
                    idle_next    = '0;
                    phase_next   = PH_HUNT1;
                end
                else
                begin
                    idle_next = idle_inc;
                end
            end
        end
        else
        begin
            // every byte rearms the timer
            idle_next    = '0;
            running_next = 1'b1;

            unique case (phase_reg)
                PH_HUNT2:
                begin
                    phase_next = (item.rx_byte == SYNC_SECOND) ? PH_LEN : PH_HUNT1;
                end
                PH_LEN:
                begin
                    length_next = item.rx_byte;
                    count_next  = '0;
                    sum_next    = '0;
                    phase_next  = (item.rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA:
                begin
                    has_result = 1'b1;
                    sum_next   = sum_reg + item.rx_byte;
                    count_next = count_inc;
                    if (count_inc == length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    has_result          = 1'b1;
                    result.result_kind  = KIND_FRAME_END;
                    result.byte_index   = '0;
                    result.frame_ok     = sum_match;
                    if (!sum_match)
                    begin
                        errors_next = errors_reg + 8'd1;
                    end
                    result.error_count  = errors_next;
                    phase_next          = PH_HUNT1;
                end
                default:
                begin
                    phase_next = (item.rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

endmodule

// File: rtl/sync_length_checksum_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit
// Sync-pair, length-prefixed frame parser with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Items are received bytes or idle-timer ticks. The parser hunts for the sync
// pair FF FE, reads a length byte and passes each payload byte on as a result,
// then checks the closing checksum byte against the 8-bit sum of the payload
// and reports the frame end with its status and the running mismatch count.
// One item is accepted per clock while the output is not stalled: it sits
// in an input register, the parser updates its state from it and any result
// lands in the output register. A stalled output holds the parser, so at
// most one more item waits in the input register. timeout_ticks may only be
// written while no item is in flight.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_unit
    import slcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic [15:0] timeout_reg;

    logic        advance;
    logic        has_result;
    out_item_t   result;

    // the held item moves on when the output register can take a result
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_item_reg <= in_item;
        end
    end

    // parser
    slcd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .item          (s1_item_reg),
        .timeout_ticks (timeout_reg),
        .has_result    (has_result),
        .result        (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= has_result;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    // input only stalls while an item is held
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    // a tick never yields a result
    a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.mode == MODE_TICK && !out_valid_reg) |=> !out_valid_reg)
        else $error("tick produced a result");

    // payload results carry no status
    a_payload_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.result_kind == KIND_PAYLOAD) |-> !out_item_reg.frame_ok)
        else $error("payload result with frame_ok set");

    // frame end results carry index zero
    a_end_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.result_kind == KIND_FRAME_END)
            |-> (out_item_reg.byte_index == 8'd0))
        else $error("frame end result with nonzero byte_index");
`endif

endmodule

// File: bench/tb_sync_length_checksum_deframer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_length_checksum_deframer_unit
// Self-checking bench for the sync/length/checksum frame parser.
// ----------------------------------------------------------------------------
// A short table of hand-picked items comes first: sync hunting, the wrong
// second sync byte, a zero-length frame, a checksum mismatch and an idle
// timeout. Some rows carry the exact result. Random traffic follows under
// several timeout settings, including both ends of the range. Most of it is
// well-formed frames with random payloads, and the rest is broken syncs,
// abandoned frames and noise. A final burst of short bad frames runs until
// the error counter has wrapped. Every accepted item goes through a local
// parser model. Each result from the block is compared field by field with
// the oldest pending prediction. Random gaps on the input side and random
// stalls on the output side are applied in all but the first random phase.
// ----------------------------------------------------------------------------
module tb_sync_length_checksum_deframer_unit;
    import slcd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 240;
    localparam int WRAP_ERRORS  = 260;

    // directed table
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_TICK,
        ROW_TIMEOUT
    } row_op_t;

    typedef struct packed {
        row_op_t     op;
        logic [15:0] value;
        logic        typed;
        out_item_t   result;
    } stim_row_t;

    localparam int ROW_COUNT = 29;
    localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        // tick while the idle timer is stopped, then hunting noise
        '{ROW_TICK,    16'h0000, 1'b0, '0},
        '{ROW_BYTE,    16'h0000, 1'b0, '0},
        // wrong second sync byte (a repeated first sync byte)
        '{ROW_BYTE,    16'h00FF, 1'b0, '0},
        '{ROW_BYTE,    16'h00FF, 1'b0, '0},
        '{ROW_BYTE,    16'h00FE, 1'b0, '0},
        // zero-length frame, checksum 0
        '{ROW_BYTE,    16'h00FF, 1'b0, '0},
        '{ROW_BYTE,    16'h00FE, 1'b0, '0},
        '{ROW_BYTE,    16'h0000, 1'b0, '0},
        '{ROW_BYTE,    16'h0000, 1'b1,
          '{KIND_FRAME_END, 8'h00, 8'd0, 1'b1, 8'd0, 8'd0}},
        // two-byte frame whose sum wraps, bad checksum
        '{ROW_BYTE,    16'h00FF, 1'b0, '0},
        '{ROW_BYTE,    16'h00FE, 1'b0, '0},
        '{ROW_BYTE,    16'h0002, 1'b0, '0},
        '{ROW_BYTE,    16'h00FF, 1'b1,
          '{KIND_PAYLOAD, 8'hFF, 8'd0, 1'b0, 8'd2, 8'd0}},
        '{ROW_BYTE,    16'h0001, 1'b1,
          '{KIND_PAYLOAD, 8'h01, 8'd1, 1'b0, 8'd2, 8'd0}},
        '{ROW_BYTE,    16'h0055, 1'b1,
          '{KIND_FRAME_END, 8'h55, 8'd0, 1'b0, 8'd2, 8'd1}},
        // one-byte frame, good checksum
        '{ROW_BYTE,    16'h00FF, 1'b0, '0},
        '{ROW_BYTE,    16'h00FE, 1'b0, '0},
        '{ROW_BYTE,    16'h0001, 1'b0, '0},
        '{ROW_BYTE,    16'h0080, 1'b1,
          '{KIND_PAYLOAD, 8'h80, 8'd0, 1'b0, 8'd1, 8'd1}},
        '{ROW_BYTE,    16'h0080, 1'b1,
          '{KIND_FRAME_END, 8'h80, 8'd0, 1'b1, 8'd1, 8'd1}},
        // shortest timeout abandons a partial frame
        '{ROW_TIMEOUT, 16'd1,    1'b0, '0},
        '{ROW_BYTE,    16'h00FF, 1'b0, '0},
        '{ROW_BYTE,    16'h00FE, 1'b0, '0},
        '{ROW_BYTE,    16'h0003, 1'b0, '0},
        '{ROW_BYTE,    16'h00AA, 1'b0, '0},
        '{ROW_TICK,    16'h0000, 1'b0, '0},
        '{ROW_BYTE,    16'h00AA, 1'b0, '0},
        '{ROW_TICK,    16'h0000, 1'b0, '0},
        // longest timeout
        '{ROW_TIMEOUT, 16'hFFFF, 1'b0, '0}
    };

    // phase settings for the random part: timeout, input gap %, output stall %
    localparam int PHASE_COUNT = 6;
    localparam logic [15:0] PHASE_TIMEOUT [PHASE_COUNT] =
        '{16'd1, 16'hFFFF, 16'd5, 16'd1000, 16'd20, 16'd2};
    localparam int PHASE_GAP   [PHASE_COUNT] = '{0, 30, 10, 50, 20, 60};
    localparam int PHASE_STALL [PHASE_COUNT] = '{0, 30, 50, 10, 20, 60};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_item   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_data  = '0;

    // parser model state
    phase_t      parser_phase = PH_HUNT1;
    logic [7:0]  frame_len    = '0;
    logic [7:0]  payload_cnt  = '0;
    logic [7:0]  payload_sum  = '0;
    logic [7:0]  bad_frames   = '0;
    logic [15:0] idle_cnt     = '0;
    logic        timer_on     = 1'b0;
    logic [15:0] timeout_val  = TIMEOUT_RESET;
    int          bad_total    = 0;

    // results the block still owes, oldest first
    out_item_t   parsed_results [$];
    out_item_t   wanted;

    int          mismatches  = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    int          gap_pct     = 20;
    int          stall_pct   = 20;
    int          stall_left  = 0;

    sync_length_checksum_deframer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one item through the parser model, returns 1 when a result is due
    function automatic bit parse_step(input in_item_t it, output out_item_t res);
        bit has_res;
        bit ok;
        has_res = 1'b0;
        res     = '0;
        if (it.mode == MODE_TICK)
        begin
            if (timer_on)
            begin
                idle_cnt = idle_cnt + 16'd1;
                if (idle_cnt >= timeout_val)
                begin
                    timer_on     = 1'b0;
                    idle_cnt     = '0;
                    parser_phase = PH_HUNT1;
                end
            end
            return 1'b0;
        end
        case (parser_phase)
            PH_HUNT2:
            begin
                parser_phase = (it.rx_byte == SYNC_SECOND) ? PH_LEN : PH_HUNT1;
            end
            PH_LEN:
            begin
                frame_len    = it.rx_byte;
                payload_cnt  = '0;
                payload_sum  = '0;
                parser_phase = (it.rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA:
            begin
                res = '{KIND_PAYLOAD, it.rx_byte, payload_cnt, 1'b0, frame_len,
                        bad_frames};
                has_res     = 1'b1;
                payload_sum = payload_sum + it.rx_byte;
                payload_cnt = payload_cnt + 8'd1;
                if (payload_cnt == frame_len)
                    parser_phase = PH_CHECK;
            end
            PH_CHECK:
            begin
                ok = (payload_sum == it.rx_byte);
                if (!ok)
                begin
                    bad_frames = bad_frames + 8'd1;
                    bad_total++;
                end
                res = '{KIND_FRAME_END, it.rx_byte, 8'd0, ok, frame_len, bad_frames};
                has_res      = 1'b1;
                parser_phase = PH_HUNT1;
            end
            default:
            begin
                parser_phase = (it.rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
        idle_cnt = '0;
        timer_on = 1'b1;
        return has_res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic flag(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            flag($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // drive one item, wait for its acceptance, then record what it must produce
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t fixed);
        int        gap;
        bit        has_res;
        out_item_t res;
        gap = pick_gap(gap_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        has_res = parse_step(it, res);
        if (typed)
            parsed_results.push_back(fixed);
        else if (has_res)
            parsed_results.push_back(res);
    endtask

    task automatic push_byte(input logic [7:0] b);
        send_item('{MODE_BYTE, b}, 1'b0, '0);
    endtask

    task automatic push_tick();
        send_item('{MODE_TICK, 8'($urandom)}, 1'b0, '0);
    endtask

    // write the timeout register once the block has gone quiet
    task automatic set_timeout(input logic [15:0] v);
        in_valid <= 1'b0;
        while (parsed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        timeout_val  = v;
    endtask

    // a few ticks that stay short of the timeout
    task automatic maybe_idle();
        int lim;
        lim = (timeout_val > 16'd4) ? 3 : int'(timeout_val) - 1;
        if (lim > 0 && $urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, lim)) push_tick();
    endtask

    // sync pair, length, payload and checksum; an abandoned frame stops early
    task automatic send_frame(input int len, input bit corrupt, input bit abandon);
        logic [7:0] sum;
        logic [7:0] b;
        int         stop;
        sum  = '0;
        stop = abandon ? $urandom_range(0, len - 1) : len;
        push_byte(SYNC_FIRST);
        maybe_idle();
        push_byte(SYNC_SECOND);
        maybe_idle();
        push_byte(8'(len));
        for (int k = 0; k < stop; k++)
        begin
            maybe_idle();
            b   = 8'($urandom);
            sum = sum + b;
            push_byte(b);
        end
        if (abandon)
        begin
            if (timeout_val <= 16'd64)
                repeat (timeout_val) push_tick();
        end
        else
        begin
            maybe_idle();
            push_byte(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
        end
    endtask

    function automatic int pick_len();
        int x;
        x = $urandom_range(0, 999);
        if (x < 200)
            return 0;
        if (x < 850)
            return $urandom_range(1, 8);
        if (x < 995)
            return $urandom_range(9, 40);
        return $urandom_range(200, 255);
    endfunction

    // mixed traffic until the item count reaches target
    task automatic mixed_traffic(input int target);
        int         r;
        logic [7:0] b;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                send_frame(pick_len(), $urandom_range(0, 99) < 30, 1'b0);
            end
            else if (r < 75)
            begin
                // broken sync pair
                push_byte(SYNC_FIRST);
                b = 8'($urandom);
                if (b == SYNC_SECOND || $urandom_range(0, 1) == 0)
                    b = SYNC_FIRST;
                push_byte(b);
            end
            else if (r < 85)
            begin
                send_frame($urandom_range(1, 12), 1'b0, 1'b1);
            end
            else
            begin
                // noise, leaning on the sync values
                repeat ($urandom_range(1, 6))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        push_tick();
                    else if (r < 55)
                        push_byte(SYNC_FIRST);
                    else if (r < 65)
                        push_byte(SYNC_SECOND);
                    else
                        push_byte(8'($urandom));
                end
            end
        end
    endtask

    // result check and output stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (parsed_results.size() == 0)
                begin
                    flag("result item with nothing pending");
                end
                else
                begin
                    wanted = parsed_results.pop_front();
                    check_field("result_kind", out_item.result_kind, wanted.result_kind);
                    check_field("data_byte", out_item.data_byte, wanted.data_byte);
                    check_field("byte_index", out_item.byte_index, wanted.byte_index);
                    check_field("frame_ok", out_item.frame_ok, wanted.frame_ok);
                    check_field("frame_length", out_item.frame_length,
                                wanted.frame_length);
                    check_field("error_count", out_item.error_count, wanted.error_count);
                end
            end
            if (stall_left == 0)
                stall_left = pick_gap(stall_pct);
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // stimulus
    initial
    begin
        int target;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            case (DIRECTED_ROWS[i].op)
                ROW_TIMEOUT: set_timeout(DIRECTED_ROWS[i].value);
                ROW_TICK:    push_tick();
                default:     send_item('{MODE_BYTE, DIRECTED_ROWS[i].value[7:0]},
                                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
            endcase
        end

        // random traffic under each setting
        target = items_sent;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_timeout(PHASE_TIMEOUT[p]);
            gap_pct   = PHASE_GAP[p];
            stall_pct = PHASE_STALL[p];
            target    = target + RANDOM_ITEMS / PHASE_COUNT;
            mixed_traffic(target);
        end

        // empty bad frames until the error counter wraps
        gap_pct   = 15;
        stall_pct = 15;
        while (bad_total < WRAP_ERRORS)
            send_frame(0, 1'b1, 1'b0);

        // drain
        in_valid <= 1'b0;
        while (parsed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/slcd_pkg.sv
rtl/slcd_parser.sv
rtl/sync_length_checksum_deframer_unit.sv
bench/tb_sync_length_checksum_deframer_unit.sv
